>>> src/scot_pkg.sv
// Shared types, constants and tables for the sector / circle overlap test.
package scot_pkg;

  localparam int COORD_BITS_DEF   = 16;
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_STEPS        = 24;
  localparam int XFRAC            = 16;  // extra fraction bits inside the CORDIC
  localparam int ROT_W            = 34;  // rotation lane width
  localparam int FIELD_W          = 16;
  localparam int REG_W            = 15;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 16;

  localparam logic [31:0]      INV_GAIN      = 32'h9B74EDA8;
  localparam logic [REG_W-1:0] HALF_VIEW_RST = 15'd3641;

  // atan(2^-i) as a fraction of a turn, 32-bit binary angle
  localparam logic [31:0] ATAN_TAB [MAX_STEPS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SECTOR_RADIUS   = 2'd0,
    CFG_TARGET_RADIUS   = 2'd1,
    CFG_HALF_VIEW_ANGLE = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CAUSE_NONE   = 3'd0,
    CAUSE_CENTER = 3'd1,
    CAUSE_ARC    = 3'd2,
    CAUSE_EDGE   = 3'd3,
    CAUSE_VIEWER = 3'd4
  } hit_cause_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] viewer_x;
    logic signed [FIELD_W-1:0] viewer_y;
    logic signed [FIELD_W-1:0] heading;
    logic signed [FIELD_W-1:0] target_x;
    logic signed [FIELD_W-1:0] target_y;
  } in_item_t;

  typedef struct packed {
    logic       hit;
    hit_cause_t hit_cause;
  } out_item_t;

endpackage

>>> src/sector_circle_overlap_test_top.sv
// Top level of the sector / circle overlap test pipeline.
//
// One transaction in gives one transaction out: a viewer position and heading
// plus a target centre go in, and hit / hit_cause come out, in order. The block
// accepts one transaction every clock cycle while in_stall is low. The CORDIC
// lanes spend one register stage per micro-rotation. Three lanes run side by
// side: one vectoring lane finds the direction to the target, two rotation
// lanes build the two sector edge end points. After them the SC, P1 to P4 and
// output stages evaluate squared distances and the edge segment tests. Each
// stage holds its own valid bit and advances whenever the stage after it is
// empty or moving, so bubbles collapse and a stalled output does not stop
// upstream stages until they fill. Configuration goes through the cfg_ port
// (always ready) and must only be written while no transaction is in flight.

module sector_circle_overlap_test_top #(
  parameter int COORD_BITS   = scot_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS   = scot_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = scot_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  scot_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output scot_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [scot_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scot_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import scot_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int AB    = ANGLE_BITS;
  localparam int NSTEP = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int DW    = CB + 1;              // coordinate difference
  localparam int D2W   = 2 * DW;              // squared distance
  localparam int VW    = DW + XFRAC + 2;      // vectoring lane
  localparam int RW    = ROT_W;               // rotation lane
  localparam int EW    = RW - XFRAC;          // edge offset
  localparam int PW    = DW + EW;             // dx * ex
  localparam int DOTW  = PW + 1;
  localparam int FW    = ((DW > EW) ? DW : EW) + 1;
  localparam int LW    = 2 * EW;
  localparam int F2W   = 2 * FW;
  localparam int GW    = ((DOTW > LW) ? DOTW : LW) + 1;
  localparam int CMPW0 = (D2W > F2W) ? D2W : F2W;
  localparam int CMPW  = (CMPW0 > 33) ? CMPW0 : 33;
  localparam int HALF_I = 1 << (AB - 1);
  localparam int QTR_I  = 1 << (AB - 2);
  localparam int NS     = NSTEP + 8;
  // stage numbers after the CORDIC lanes
  localparam int ST_SC  = NSTEP + 2;
  localparam int ST_P1  = NSTEP + 3;
  localparam int ST_P2  = NSTEP + 4;
  localparam int ST_P3  = NSTEP + 5;
  localparam int ST_P4  = NSTEP + 6;
  localparam int ST_OUT = NSTEP + 7;

  localparam logic signed [AB:0] HALF_Z = (AB+1)'(HALF_I);

  // cut to CB bits and sign extend; wider than the field keeps it positive
  function automatic logic signed [DW-1:0] coord_f(input logic [FIELD_W-1:0] raw);
    logic [CB-1:0] v;
    v = CB'(raw);
    return DW'(signed'(v));
  endfunction

  // 65536-per-turn angle rescaled to AB bits
  function automatic logic [AB-1:0] ba_f(input logic [FIELD_W-1:0] a);
    logic [AB+FIELD_W-1:0] t;
    t = {a, {AB{1'b0}}};
    return t[AB+FIELD_W-1:FIELD_W];
  endfunction

  // ---------------------------------------------------------------- config
  logic [REG_W-1:0] sector_radius_r, target_radius_r, half_view_r;
  logic [29:0]      rs2_r, rt2_r, diff2_r;
  logic [31:0]      sum2_r;
  logic [REG_W-1:0] rdiff;
  logic [REG_W:0]   rsum;
  logic [AB-1:0]    half_a;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_radius_r <= '0;
      target_radius_r <= '0;
      half_view_r     <= HALF_VIEW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SECTOR_RADIUS:   sector_radius_r <= cfg_data[REG_W-1:0];
        CFG_TARGET_RADIUS:   target_radius_r <= cfg_data[REG_W-1:0];
        CFG_HALF_VIEW_ANGLE: half_view_r     <= cfg_data[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // squared radii, only read near the end of the pipe
  assign rdiff = (sector_radius_r >= target_radius_r) ? sector_radius_r - target_radius_r
                                                       : target_radius_r - sector_radius_r;
  assign rsum  = (REG_W+1)'(sector_radius_r) + (REG_W+1)'(target_radius_r);

  always_ff @(posedge clk) begin
    rs2_r   <= 30'(sector_radius_r) * 30'(sector_radius_r);
    rt2_r   <= 30'(target_radius_r) * 30'(target_radius_r);
    diff2_r <= 30'(rdiff) * 30'(rdiff);
    sum2_r  <= 32'(rsum) * 32'(rsum);
  end

  assign half_a = ba_f({1'b0, half_view_r});

  // ---------------------------------------------------------------- flow
  // each stage moves when it is empty or the next one moves
  logic [NS-1:0] v_r, v_nxt, en;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt = v_r;
    if (en[0]) v_nxt[0] = in_valid;
    for (int k = 1; k < NS; k++) begin
      if (en[k]) v_nxt[k] = v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NS-1];

  // ---------------------------------------------------------------- stage 0
  logic signed [DW-1:0] dx0_r, dy0_r;
  logic [AB-1:0]        head0_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx0_r   <= coord_f(in_data.target_x) - coord_f(in_data.viewer_x);
      dy0_r   <= coord_f(in_data.target_y) - coord_f(in_data.viewer_y);
      head0_r <= ba_f(in_data.heading);
    end
  end

  // ---------------------------------------------------------------- stage 1
  // lane setup: vector start folded into the upper half plane, edge angles
  // folded into +/- a quarter turn with a flip flag
  logic signed [VW-1:0] vu_r, vv_r;
  logic [AB-1:0]        vz_r;
  logic signed [RW-1:0] ru0_r;
  logic signed [AB:0]   rz_r [2];
  logic [D2W-1:0]       sqx_r, sqy_r;
  logic signed [AB:0]   zs   [2];
  logic signed [AB:0]   zf   [2];
  logic [1:0]           flp;
  logic [AB-1:0]        ea   [2];
  logic [REG_W+31:0]    u0_prod;

  always_comb begin
    ea[0] = head0_r - half_a;
    ea[1] = head0_r + half_a;
    for (int l = 0; l < 2; l++) begin
      zs[l]  = (AB+1)'(signed'(ea[l]));
      zf[l]  = zs[l];
      flp[l] = 1'b0;
      if (zs[l] > QTR_I) begin
        zf[l]  = zs[l] - HALF_Z;
        flp[l] = 1'b1;
      end else if (zs[l] < -QTR_I) begin
        zf[l]  = zs[l] + HALF_Z;
        flp[l] = 1'b1;
      end
    end
    u0_prod = (REG_W+32)'(sector_radius_r) * (REG_W+32)'(INV_GAIN);
  end

  // pass-through of per-transaction values alongside the lanes
  logic signed [DW-1:0] dx_c_r   [NSTEP+1];
  logic signed [DW-1:0] dy_c_r   [NSTEP+1];
  logic [AB-1:0]        head_c_r [NSTEP+1];
  logic                 zero_c_r [NSTEP+1];
  logic [1:0]           flip_c_r [NSTEP+1];
  logic [D2W-1:0]       d2_c_r   [NSTEP];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      if (dy0_r < 0) begin
        vu_r <= -(VW'(dy0_r) <<< XFRAC);
        vv_r <= -(VW'(dx0_r) <<< XFRAC);
        vz_r <= AB'(HALF_I);
      end else begin
        vu_r <= VW'(dy0_r) <<< XFRAC;
        vv_r <= VW'(dx0_r) <<< XFRAC;
        vz_r <= '0;
      end
      ru0_r       <= RW'(u0_prod >> XFRAC);
      rz_r[0]     <= zf[0];
      rz_r[1]     <= zf[1];
      sqx_r       <= D2W'(dx0_r) * D2W'(dx0_r);
      sqy_r       <= D2W'(dy0_r) * D2W'(dy0_r);
      dx_c_r[0]   <= dx0_r;
      dy_c_r[0]   <= dy0_r;
      head_c_r[0] <= head0_r;
      zero_c_r[0] <= (dx0_r == 0) && (dy0_r == 0);
      flip_c_r[0] <= flp;
    end
  end

  for (genvar m = 1; m <= NSTEP; m++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en[1+m]) begin
        dx_c_r[m]   <= dx_c_r[m-1];
        dy_c_r[m]   <= dy_c_r[m-1];
        head_c_r[m] <= head_c_r[m-1];
        zero_c_r[m] <= zero_c_r[m-1];
        flip_c_r[m] <= flip_c_r[m-1];
      end
    end
    if (m == 1) begin : g_d2
      always_ff @(posedge clk) begin
        if (en[1+m]) d2_c_r[0] <= sqx_r + sqy_r;
      end
    end else begin : g_d2c
      always_ff @(posedge clk) begin
        if (en[1+m]) d2_c_r[m-1] <= d2_c_r[m-2];
      end
    end
  end

  // ---------------------------------------------------------------- CORDIC
  logic signed [VW-1:0] vu_o, vv_o;
  logic [AB-1:0]        vz_o;
  logic signed [RW-1:0] ru_o [2];
  logic signed [RW-1:0] rv_o [2];
  logic signed [AB:0]   rz_o [2];

  scot_cordic #(
    .W(VW), .ZW(AB), .AB(AB), .NSTEP(NSTEP), .ROTATE(1'b0)
  ) u_vec (
    .clk (clk),
    .en  (en[NSTEP+1:2]),
    .u_i (vu_r),
    .v_i (vv_r),
    .z_i (vz_r),
    .u_o (vu_o),
    .v_o (vv_o),
    .z_o (vz_o)
  );

  for (genvar l = 0; l < 2; l++) begin : g_edge
    scot_cordic #(
      .W(RW), .ZW(AB+1), .AB(AB), .NSTEP(NSTEP), .ROTATE(1'b1)
    ) u_rot (
      .clk (clk),
      .en  (en[NSTEP+1:2]),
      .u_i (ru0_r),
      .v_i ('0),
      .z_i (rz_r[l]),
      .u_o (ru_o[l]),
      .v_o (rv_o[l]),
      .z_o (rz_o[l])
    );
  end

  // ---------------------------------------------------------------- SC
  // sector membership by wrapped angle offset; edges rounded to signed Q18.0 integers
  logic [AB-1:0]        zdir, aoff;
  logic signed [AB:0]   offs;
  logic [AB:0]          offa;
  logic signed [RW-1:0] vf [2];
  logic signed [RW-1:0] uf [2];
  logic signed [RW-1:0] rnd_x [2];
  logic signed [RW-1:0] rnd_y [2];
  logic signed [AB:0]   zres_unused_chk [2];

  always_comb begin
    zdir = zero_c_r[NSTEP] ? '0 : vz_o;
    aoff = zdir - head_c_r[NSTEP];
    offs = (AB+1)'(signed'(aoff));
    offa = (offs < 0) ? unsigned'(-offs) : unsigned'(offs);
    for (int l = 0; l < 2; l++) begin
      zres_unused_chk[l] = rz_o[l];
      vf[l] = flip_c_r[NSTEP][l] ? -rv_o[l] : rv_o[l];
      uf[l] = flip_c_r[NSTEP][l] ? -ru_o[l] : ru_o[l];
      rnd_x[l] = (vf[l] + RW'(1 << (XFRAC - 1))) >>> XFRAC;
      rnd_y[l] = (uf[l] + RW'(1 << (XFRAC - 1))) >>> XFRAC;
    end
  end

  logic signed [DW-1:0] dx_sc_r, dy_sc_r;
  logic [D2W-1:0]       d2_sc_r;
  logic                 in_sc_r;
  logic signed [EW-1:0] ex_sc_r [2];
  logic signed [EW-1:0] ey_sc_r [2];

  always_ff @(posedge clk) begin
    if (en[ST_SC]) begin
      dx_sc_r <= dx_c_r[NSTEP];
      dy_sc_r <= dy_c_r[NSTEP];
      d2_sc_r <= d2_c_r[NSTEP-1];
      in_sc_r <= (offa <= {1'b0, half_a});
      for (int l = 0; l < 2; l++) begin
        ex_sc_r[l] <= EW'(rnd_x[l]);
        ey_sc_r[l] <= EW'(rnd_y[l]);
      end
    end
  end

  // ---------------------------------------------------------------- P1
  logic signed [PW-1:0] dxe_p1_r [2];
  logic signed [PW-1:0] dye_p1_r [2];
  logic [LW-1:0]        exx_p1_r [2];
  logic [LW-1:0]        eyy_p1_r [2];
  logic signed [FW-1:0] fx_p1_r  [2];
  logic signed [FW-1:0] fy_p1_r  [2];
  logic [D2W-1:0]       d2_p1_r;
  logic                 in_p1_r;

  always_ff @(posedge clk) begin
    if (en[ST_P1]) begin
      d2_p1_r <= d2_sc_r;
      in_p1_r <= in_sc_r;
      for (int l = 0; l < 2; l++) begin
        dxe_p1_r[l] <= PW'(dx_sc_r) * PW'(ex_sc_r[l]);
        dye_p1_r[l] <= PW'(dy_sc_r) * PW'(ey_sc_r[l]);
        exx_p1_r[l] <= LW'(ex_sc_r[l]) * LW'(ex_sc_r[l]);
        eyy_p1_r[l] <= LW'(ey_sc_r[l]) * LW'(ey_sc_r[l]);
        fx_p1_r[l]  <= FW'(dx_sc_r) - FW'(ex_sc_r[l]);
        fy_p1_r[l]  <= FW'(dy_sc_r) - FW'(ey_sc_r[l]);
      end
    end
  end

  // ---------------------------------------------------------------- P2
  logic [LW-1:0]          len2_p2_r [2];
  logic signed [DOTW-1:0] dot_p2_r  [2];
  logic [F2W-1:0]         fxx_p2_r  [2];
  logic [F2W-1:0]         fyy_p2_r  [2];
  logic [D2W-1:0]         d2_p2_r;
  logic                   in_p2_r;

  always_ff @(posedge clk) begin
    if (en[ST_P2]) begin
      d2_p2_r <= d2_p1_r;
      in_p2_r <= in_p1_r;
      for (int l = 0; l < 2; l++) begin
        len2_p2_r[l] <= exx_p1_r[l] + eyy_p1_r[l];
        dot_p2_r[l]  <= DOTW'(dxe_p1_r[l]) + DOTW'(dye_p1_r[l]);
        fxx_p2_r[l]  <= F2W'(fx_p1_r[l]) * F2W'(fx_p1_r[l]);
        fyy_p2_r[l]  <= F2W'(fy_p1_r[l]) * F2W'(fy_p1_r[l]);
      end
    end
  end

  // ---------------------------------------------------------------- P3
  // interior projection products; only meaningful when the distance is
  // within the summed radii, which keeps them inside 32 bits per operand
  logic [31:0] w2, len2l [2], dotl [2];

  always_comb begin
    w2 = 32'(d2_p2_r);
    for (int l = 0; l < 2; l++) begin
      len2l[l] = 32'(len2_p2_r[l]);
      dotl[l]  = 32'(dot_p2_r[l]);
    end
  end

  logic [63:0]    wl_p3_r  [2];
  logic [63:0]    rl_p3_r  [2];
  logic [63:0]    dd_p3_r  [2];
  logic [F2W-1:0] fs_p3_r  [2];
  logic [1:0]     len0_p3_r, dle0_p3_r, dge_p3_r;
  logic [D2W-1:0] d2_p3_r;
  logic           in_p3_r;

  always_ff @(posedge clk) begin
    if (en[ST_P3]) begin
      d2_p3_r <= d2_p2_r;
      in_p3_r <= in_p2_r;
      for (int l = 0; l < 2; l++) begin
        wl_p3_r[l]   <= 64'(w2) * 64'(len2l[l]);
        rl_p3_r[l]   <= 64'(rt2_r) * 64'(len2l[l]);
        dd_p3_r[l]   <= 64'(dotl[l]) * 64'(dotl[l]);
        fs_p3_r[l]   <= fxx_p2_r[l] + fyy_p2_r[l];
        len0_p3_r[l] <= (len2_p2_r[l] == '0);
        dle0_p3_r[l] <= (dot_p2_r[l] <= 0);
        dge_p3_r[l]  <= !dot_p2_r[l][DOTW-1] &&
                        (GW'(unsigned'(dot_p2_r[l])) >= GW'(len2_p2_r[l]));
      end
    end
  end

  // ---------------------------------------------------------------- P4
  logic [63:0] wl_p4_r  [2];
  logic [64:0] rhs_p4_r [2];
  logic [1:0]  len0_p4_r, dle0_p4_r, dge_p4_r, fle_p4_r;
  logic        near_p4_r, c1_p4_r, c2_p4_r, wle_p4_r;

  always_ff @(posedge clk) begin
    if (en[ST_P4]) begin
      near_p4_r <= CMPW'(d2_p3_r) <= CMPW'(sum2_r);
      c1_p4_r   <= (CMPW'(d2_p3_r) <= CMPW'(rs2_r)) && in_p3_r;
      c2_p4_r   <= (CMPW'(d2_p3_r) < CMPW'(sum2_r)) &&
                   (CMPW'(d2_p3_r) > CMPW'(diff2_r)) && in_p3_r;
      wle_p4_r  <= CMPW'(d2_p3_r) <= CMPW'(rt2_r);
      len0_p4_r <= len0_p3_r;
      dle0_p4_r <= dle0_p3_r;
      dge_p4_r  <= dge_p3_r;
      for (int l = 0; l < 2; l++) begin
        wl_p4_r[l]  <= wl_p3_r[l];
        rhs_p4_r[l] <= 65'(rl_p3_r[l]) + 65'(dd_p3_r[l]);
        fle_p4_r[l] <= CMPW'(fs_p3_r[l]) <= CMPW'(rt2_r);
      end
    end
  end

  // ---------------------------------------------------------------- output
  logic [1:0] meet;
  hit_cause_t cause;
  out_item_t  out_r;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (len0_p4_r[l])      meet[l] = 1'b0;       // degenerate edge
      else if (dle0_p4_r[l]) meet[l] = wle_p4_r;   // closest point is the viewer
      else if (dge_p4_r[l])  meet[l] = fle_p4_r[l];// closest point is the far end
      else                   meet[l] = 65'(wl_p4_r[l]) <= rhs_p4_r[l];
    end
    if (!near_p4_r)    cause = CAUSE_NONE;
    else if (c1_p4_r)  cause = CAUSE_CENTER;
    else if (c2_p4_r)  cause = CAUSE_ARC;
    else if (|meet)    cause = CAUSE_EDGE;
    else if (wle_p4_r) cause = CAUSE_VIEWER;
    else               cause = CAUSE_NONE;
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_r.hit       <= (cause != CAUSE_NONE);
      out_r.hit_cause <= cause;
    end
  end

  assign out_data = out_r;

endmodule

>>> src/scot_cordic.sv
// Pipelined CORDIC lane, one micro-rotation per register stage.
module scot_cordic #(
  parameter int W      = 34,
  parameter int ZW     = 17,
  parameter int AB     = 16,
  parameter int NSTEP  = 16,
  parameter bit ROTATE = 1'b1
) (
  input  logic                clk,
  input  logic [NSTEP-1:0]    en,
  input  logic signed [W-1:0] u_i,
  input  logic signed [W-1:0] v_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [W-1:0] u_o,
  output logic signed [W-1:0] v_o,
  output logic signed [ZW-1:0] z_o
);
  import scot_pkg::*;

  logic signed [W-1:0]  u_r [NSTEP];
  logic signed [W-1:0]  v_r [NSTEP];
  logic signed [ZW-1:0] z_r [NSTEP];

  for (genvar j = 0; j < NSTEP; j++) begin : g_stage
    logic signed [W-1:0]  u_p, v_p;
    logic signed [ZW-1:0] z_p, ang;
    logic                 take;

    if (j == 0) begin : g_first
      assign u_p = u_i;
      assign v_p = v_i;
      assign z_p = z_i;
    end else begin : g_next
      assign u_p = u_r[j-1];
      assign v_p = v_r[j-1];
      assign z_p = z_r[j-1];
    end

    assign ang = ZW'(ATAN_TAB[j] >> (32 - AB));

    // rotation follows the residual angle, vectoring drives v toward zero
    if (ROTATE) begin : g_rot
      assign take = (z_p >= 0);
    end else begin : g_vec
      assign take = (v_p <= 0);
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        if (take) begin
          u_r[j] <= u_p - (v_p >>> j);
          v_r[j] <= v_p + (u_p >>> j);
          z_r[j] <= z_p - ang;
        end else begin
          u_r[j] <= u_p + (v_p >>> j);
          v_r[j] <= v_p - (u_p >>> j);
          z_r[j] <= z_p + ang;
        end
      end
    end
  end

  assign u_o = u_r[NSTEP-1];
  assign v_o = v_r[NSTEP-1];
  assign z_o = z_r[NSTEP-1];

endmodule
